### rtl/kart_pkg.sv
package kart_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;
  localparam int unsigned CfgW = 31;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DivStepsW = 6;

  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] FixOne = WordW'(1) <<< FracW;

  localparam logic [AddrW-1:0] AddrStep = 5'd0;
  localparam logic [AddrW-1:0] AddrQa = 5'd4;
  localparam logic [AddrW-1:0] AddrQr = 5'd8;
  localparam logic [AddrW-1:0] AddrR = 5'd12;
  localparam logic [AddrW-1:0] AddrGate = 5'd16;

  localparam logic [CfgW-1:0] RstStep = 31'd335544;
  localparam logic [CfgW-1:0] RstQa = 31'd16777;
  localparam logic [CfgW-1:0] RstQr = 31'd50332;
  localparam logic [CfgW-1:0] RstR = 31'd1677722;
  localparam logic [CfgW-1:0] RstGate = 31'd1678;

  typedef enum logic [0:0] {
    OpPredict = 1'b0,
    OpUpdate = 1'b1
  } op_e;

  // Arithmetic request into the shared serial unit
  typedef enum logic [0:0] {
    AuMul = 1'b0,
    AuDiv = 1'b1
  } au_op_e;

  typedef struct packed {
    logic start;
    au_op_e op;
  } au_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } au_sts_t;

  typedef enum logic [5:0] {
    SIdle, SPrA, SPrDiv, SPrMul0, SPrMul1, SPrFin,
    SUpA, SUpChi0, SUpChi1, SUpGate, SUpK0, SUpK1, SUpM0, SUpM1, SUpM2,
    SUpM3, SUpM4, SUpM5, SUpM6, SUpM7, SUpM8, SUpM9, SUpM10, SUpM11,
    SUpFin, SOut
  } seq_e;

  function automatic logic signed [WordW-1:0] sat_add(
    input logic signed [WordW-1:0] a, input logic signed [WordW-1:0] b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) return s[WordW] ? WordMin : WordMax;
    return s[WordW-1:0];
  endfunction

  function automatic logic signed [WordW-1:0] sat_sub(
    input logic signed [WordW-1:0] a, input logic signed [WordW-1:0] b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) return s[WordW] ? WordMin : WordMax;
    return s[WordW-1:0];
  endfunction

endpackage

### rtl/kart_if.sv
interface kart_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [kart_pkg::WordW-1:0] measurement;
  modport source(output valid, opcode, measurement, input ready);
  modport sink(input valid, opcode, measurement, output ready);
endinterface

interface kart_out_if;
  logic valid;
  logic ready;
  logic signed [kart_pkg::WordW-1:0] angle_estimate;
  logic signed [kart_pkg::WordW-1:0] rate_estimate;
  logic gated;
  logic [31:0] reject_total;
  modport source(output valid, angle_estimate, rate_estimate, gated, reject_total,
    input ready);
  modport sink(input valid, angle_estimate, rate_estimate, gated, reject_total,
    output ready);
endinterface

### rtl/kart_arith.sv
// Shared bit-serial multiplier / divider: one bit per cycle, sign-magnitude,
// magnitude truncated, result saturated to the word range.
module kart_arith (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kart_pkg::au_req_t                   req_i,
  input  logic signed [kart_pkg::WordW-1:0]   a_i,
  input  logic signed [kart_pkg::WordW-1:0]   b_i,
  output kart_pkg::au_sts_t                   sts_o,
  output logic signed [kart_pkg::WordW-1:0]   res_o
);
  localparam int unsigned W = kart_pkg::WordW;
  localparam int unsigned F = kart_pkg::FracW;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned DivN = W + F;

  logic busy_q, busy_d, done_q, done_d;
  kart_pkg::au_op_e op_q, op_d;
  logic neg_q, neg_d, zero_q, zero_d;
  logic [W-1:0] x_q, x_d;          // multiplier bits / divisor
  logic [PW-1:0] acc_q, acc_d;     // product or remainder
  logic [DivN-1:0] sh_q, sh_d;     // multiplicand / dividend-quotient
  logic [kart_pkg::DivStepsW:0] cnt_q, cnt_d;
  logic signed [W-1:0] res_q, res_d;

  logic [W-1:0] ma, mb;
  logic [PW:0] trial;
  logic [W:0] psum;
  logic [PW-1:0] mag;

  assign ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign trial = {acc_q, sh_q[DivN-1]} - {(PW+1-W)'(0), x_q};
  assign psum = {1'b0, acc_q[PW-1:W]} + (x_q[0] ? {1'b0, sh_q[W-1:0]} : (W+1)'(0));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d = op_q;
    neg_d = neg_q;
    zero_d = zero_q;
    x_d = x_q;
    acc_d = acc_q;
    sh_d = sh_q;
    cnt_d = cnt_q;
    res_d = res_q;
    mag = '0;
    if (req_i.start && !busy_q) begin
      // load operands
      busy_d = 1'b1;
      op_d = req_i.op;
      neg_d = a_i[W-1] ^ b_i[W-1];
      zero_d = (ma == '0);
      acc_d = '0;
      cnt_d = '0;
      if (req_i.op == kart_pkg::AuMul) begin
        x_d = mb;
        sh_d = DivN'(ma);
      end else begin
        x_d = mb;
        sh_d = {ma, F'(0)};
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (op_q == kart_pkg::AuMul) begin
        // add multiplicand to the upper half when bit set, then shift right
        acc_d = {psum, acc_q[W-1:1]};
        x_d = x_q >> 1;
        if (cnt_q == (kart_pkg::DivStepsW+1)'(W - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          mag = acc_d >> F;
        end
      end else begin
        // restoring division step
        if (!trial[PW]) begin
          acc_d = trial[PW-1:0];
          sh_d = {sh_q[DivN-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[PW-2:0], sh_q[DivN-1]};
          sh_d = {sh_q[DivN-2:0], 1'b0};
        end
        if (cnt_q == (kart_pkg::DivStepsW+1)'(DivN - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          mag = PW'(sh_d);
        end
      end
      if (done_d) begin
        if (op_q == kart_pkg::AuDiv && zero_q) res_d = '0;
        else if (op_q == kart_pkg::AuDiv && x_q == '0)
          res_d = neg_q ? kart_pkg::WordMin : kart_pkg::WordMax;
        else if (!neg_q)
          res_d = (mag > PW'(kart_pkg::WordMax)) ? kart_pkg::WordMax : W'(mag);
        else
          res_d = (mag > PW'({1'b1, (W-1)'(0)})) ? kart_pkg::WordMin : W'(-mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    x_q <= x_d;
    acc_q <= acc_d;
    sh_q <= sh_d;
    res_q <= res_d;
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without busy");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_d |=> busy_q) else $error("unit dropped busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (kart_pkg::DivStepsW+1)'(DivN)) else $error("count overrun");
`endif
endmodule

### rtl/kalman_angle_rate_tracker.sv
// Two-state angle / angle-rate Kalman tracker, Q8.24 fixed point.
// Input channel in_if carries opcode (0 predict with angle, 1 update with
// rate) and measurement; output channel out_if returns one word per item:
// angle and rate estimates, gated flag and the running reject count.
// The APB port writes the five 31-bit registers at byte addresses 0..16;
// reads return them. Write only while no item is in flight.
// All multiplies and divides run on one bit-serial unit, one bit per cycle.
// The input is ready again once the result is loaded into the output
// register. One item is processed at a time.
// Results go to an output register; while it holds an unaccepted word the
// next item is still accepted and processed, and the engine then waits for
// the stalled receiver before the input is ready again.
// Reset: angle and rate 0, covariance identity, reject count 0, registers
// at their documented defaults, output empty.
module kalman_angle_rate_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kart_in_if.sink                      in_if,
  kart_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kart_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  localparam int unsigned W = kart_pkg::WordW;
  typedef logic signed [W-1:0] w_t;

  logic [kart_pkg::CfgW-1:0] step_q, qa_q, qr_q, r_q, gate_q;
  w_t ang_q, ang_d, rate_q, rate_d, p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  w_t p3_q, p3_d;
  w_t meas_q, meas_d, y_q, y_d, s_q, s_d, k0_q, k0_d, k1_q, k1_d;
  w_t t0_q, t0_d, t1_q, t1_d, t2_q, t2_d, t3_q, t3_d, u_q, u_d;
  logic [31:0] rej_q, rej_d;
  logic gated_q, gated_d, ov_q, ov_d;
  w_t oang_q, oang_d, orate_q, orate_d;
  logic [31:0] orej_q, orej_d;
  logic ogated_q, ogated_d;
  kart_pkg::seq_e st_q, st_d;

  kart_pkg::au_req_t req;
  kart_pkg::au_sts_t sts;
  w_t au_a, au_b, au_r;

  w_t dt, rr;
  assign dt = w_t'({1'b0, step_q});
  assign rr = w_t'({1'b0, r_q});

  kart_arith u_arith (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .a_i(au_a), .b_i(au_b),
    .sts_o(sts), .res_o(au_r)
  );

  // Register file writes and reads
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= kart_pkg::RstStep;
      qa_q <= kart_pkg::RstQa;
      qr_q <= kart_pkg::RstQr;
      r_q <= kart_pkg::RstR;
      gate_q <= kart_pkg::RstGate;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        kart_pkg::AddrStep: step_q <= pwdata[30:0];
        kart_pkg::AddrQa: qa_q <= pwdata[30:0];
        kart_pkg::AddrQr: qr_q <= pwdata[30:0];
        kart_pkg::AddrR: r_q <= pwdata[30:0];
        kart_pkg::AddrGate: gate_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      kart_pkg::AddrStep: prdata = {1'b0, step_q};
      kart_pkg::AddrQa: prdata = {1'b0, qa_q};
      kart_pkg::AddrQr: prdata = {1'b0, qr_q};
      kart_pkg::AddrR: prdata = {1'b0, r_q};
      kart_pkg::AddrGate: prdata = {1'b0, gate_q};
      default: prdata = '0;
    endcase
  end

  assign in_if.ready = (st_q == kart_pkg::SIdle);
  assign out_if.valid = ov_q;
  assign out_if.angle_estimate = oang_q;
  assign out_if.rate_estimate = orate_q;
  assign out_if.gated = ogated_q;
  assign out_if.reject_total = orej_q;

  // Sequencer: issue at most one serial op per step, fold results into state
  always_comb begin
    st_d = st_q;
    ang_d = ang_q; rate_d = rate_q;
    p0_d = p0_q; p1_d = p1_q; p2_d = p2_q; p3_d = p3_q;
    meas_d = meas_q; y_d = y_q; s_d = s_q; k0_d = k0_q; k1_d = k1_q;
    t0_d = t0_q; t1_d = t1_q; t2_d = t2_q; t3_d = t3_q; u_d = u_q;
    rej_d = rej_q; gated_d = gated_q;
    oang_d = oang_q; orate_d = orate_q; ogated_d = ogated_q; orej_d = orej_q;
    ov_d = ov_q && !out_if.ready;
    req = '{start: 1'b0, op: kart_pkg::AuMul};
    au_a = '0; au_b = '0;
    unique case (st_q)
      kart_pkg::SIdle: begin
        if (in_if.valid && in_if.ready) begin
          meas_d = in_if.measurement;
          gated_d = 1'b0;
          st_d = (in_if.opcode == kart_pkg::OpUpdate) ? kart_pkg::SUpA
                                                       : kart_pkg::SPrA;
        end
      end
      kart_pkg::SPrA: begin
        req = '{start: 1'b1, op: kart_pkg::AuDiv};
        au_a = kart_pkg::sat_sub(meas_q, ang_q); au_b = dt;
        st_d = kart_pkg::SPrDiv;
      end
      kart_pkg::SPrDiv: if (sts.done) begin
        y_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = dt; au_b = p2_q;
        st_d = kart_pkg::SPrMul0;
      end
      kart_pkg::SPrMul0: if (sts.done) begin
        t0_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = dt; au_b = p3_q;
        st_d = kart_pkg::SPrMul1;
      end
      kart_pkg::SPrMul1: if (sts.done) begin
        t1_d = au_r;
        st_d = kart_pkg::SPrFin;
      end
      kart_pkg::SPrFin: begin
        p0_d = kart_pkg::sat_add(kart_pkg::sat_add(p0_q, t0_q), w_t'({1'b0, qa_q}));
        p1_d = kart_pkg::sat_add(p1_q, t1_q);
        p3_d = kart_pkg::sat_add(p3_q, w_t'({1'b0, qr_q}));
        ang_d = meas_q; rate_d = y_q;
        st_d = kart_pkg::SOut;
      end
      kart_pkg::SUpA: begin
        y_d = kart_pkg::sat_sub(meas_q, rate_q);
        s_d = kart_pkg::sat_add(p3_q, rr);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = kart_pkg::sat_sub(meas_q, rate_q);
        au_b = kart_pkg::sat_add(p3_q, rr);
        st_d = kart_pkg::SUpChi0;
      end
      kart_pkg::SUpChi0: if (sts.done) begin
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = au_r; au_b = y_q;
        st_d = kart_pkg::SUpChi1;
      end
      kart_pkg::SUpChi1: if (sts.done) begin
        u_d = au_r;
        st_d = kart_pkg::SUpGate;
      end
      kart_pkg::SUpGate: begin
        if (u_q > w_t'({1'b0, gate_q})) begin
          rej_d = rej_q + 32'd1; gated_d = 1'b1;
          st_d = kart_pkg::SOut;
        end else begin
          req = '{start: 1'b1, op: kart_pkg::AuDiv};
          au_a = p1_q; au_b = s_q;
          st_d = kart_pkg::SUpK0;
        end
      end
      kart_pkg::SUpK0: if (sts.done) begin
        k0_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuDiv};
        au_a = p3_q; au_b = s_q;
        st_d = kart_pkg::SUpK1;
      end
      kart_pkg::SUpK1: if (sts.done) begin
        k1_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k0_q; au_b = p2_q;
        st_d = kart_pkg::SUpM0;
      end
      kart_pkg::SUpM0: if (sts.done) begin
        t0_d = kart_pkg::sat_sub(p0_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k0_q; au_b = p3_q;
        st_d = kart_pkg::SUpM1;
      end
      kart_pkg::SUpM1: if (sts.done) begin
        t1_d = kart_pkg::sat_sub(p1_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = kart_pkg::sat_sub(kart_pkg::FixOne, k1_q); au_b = p2_q;
        st_d = kart_pkg::SUpM2;
      end
      kart_pkg::SUpM2: if (sts.done) begin
        t2_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = kart_pkg::sat_sub(kart_pkg::FixOne, k1_q); au_b = p3_q;
        st_d = kart_pkg::SUpM3;
      end
      kart_pkg::SUpM3: if (sts.done) begin
        t3_d = au_r;
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k0_q; au_b = rr;
        st_d = kart_pkg::SUpM4;
      end
      kart_pkg::SUpM4: if (sts.done) begin
        u_d = au_r; // k0*R
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = au_r; au_b = k0_q;
        st_d = kart_pkg::SUpM5;
      end
      kart_pkg::SUpM5: if (sts.done) begin
        p0_d = kart_pkg::sat_add(t0_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = u_q; au_b = k1_q;
        st_d = kart_pkg::SUpM6;
      end
      kart_pkg::SUpM6: if (sts.done) begin
        p1_d = kart_pkg::sat_add(t1_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k1_q; au_b = rr;
        st_d = kart_pkg::SUpM7;
      end
      kart_pkg::SUpM7: if (sts.done) begin
        u_d = au_r; // k1*R
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = au_r; au_b = k0_q;
        st_d = kart_pkg::SUpM8;
      end
      kart_pkg::SUpM8: if (sts.done) begin
        p2_d = kart_pkg::sat_add(t2_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = u_q; au_b = k1_q;
        st_d = kart_pkg::SUpM9;
      end
      kart_pkg::SUpM9: if (sts.done) begin
        p3_d = kart_pkg::sat_add(t3_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k0_q; au_b = y_q;
        st_d = kart_pkg::SUpM10;
      end
      kart_pkg::SUpM10: if (sts.done) begin
        ang_d = kart_pkg::sat_add(ang_q, au_r);
        req = '{start: 1'b1, op: kart_pkg::AuMul};
        au_a = k1_q; au_b = y_q;
        st_d = kart_pkg::SUpM11;
      end
      kart_pkg::SUpM11: if (sts.done) begin
        rate_d = kart_pkg::sat_add(rate_q, au_r);
        st_d = kart_pkg::SUpFin;
      end
      kart_pkg::SUpFin: st_d = kart_pkg::SOut;
      kart_pkg::SOut: begin
        // hold until the result register is free, then load it
        if (!ov_q || out_if.ready) begin
          oang_d = ang_q; orate_d = rate_q;
          ogated_d = gated_q; orej_d = rej_q;
          ov_d = 1'b1;
          st_d = kart_pkg::SIdle;
        end
      end
      default: st_d = kart_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= kart_pkg::SIdle;
      ov_q <= 1'b0;
      ang_q <= '0; rate_q <= '0;
      p0_q <= kart_pkg::FixOne; p1_q <= '0; p2_q <= '0; p3_q <= kart_pkg::FixOne;
      rej_q <= '0;
      gated_q <= 1'b0;
      oang_q <= '0; orate_q <= '0; ogated_q <= 1'b0; orej_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      ang_q <= ang_d; rate_q <= rate_d;
      p0_q <= p0_d; p1_q <= p1_d; p2_q <= p2_d; p3_q <= p3_d;
      rej_q <= rej_d;
      gated_q <= gated_d;
      oang_q <= oang_d; orate_q <= orate_d; ogated_q <= ogated_d; orej_q <= orej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q <= meas_d; y_q <= y_d; s_q <= s_d; k0_q <= k0_d; k1_q <= k1_d;
    t0_q <= t0_d; t1_q <= t1_d; t2_q <= t2_d; t3_q <= t3_d; u_q <= u_d;
  end

`ifndef SYNTHESIS
  a_rej_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q != $past(rej_q) |-> rej_q == $past(rej_q) + 32'd1 && gated_q)
    else $error("reject count jump");
  a_busy_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == kart_pkg::SIdle |-> !sts.busy) else $error("unit busy when idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid
      && $stable(out_if.angle_estimate) && $stable(out_if.reject_total))
    else $error("result word changed while stalled");
`endif
endmodule
